>>> rtl/core/smf_pkg.sv
package smf_pkg;

    localparam int BYTE_W          = 8;
    localparam int REG_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int COUNT_W         = 32;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [REG_BYTES*BYTE_W-1:0] pattern;
        logic [LEN_W-1:0]            length;
    } smf_cfg_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] start;
    } smf_result_t;

endpackage

>>> rtl/core/smf_in_if.sv
interface smf_in_if
    import smf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              starts_text;

    modport source (output valid, output text_byte, output starts_text, input ready);
    modport sink   (input valid, input text_byte, input starts_text, output ready);
endinterface

>>> rtl/core/smf_out_if.sv
interface smf_out_if
    import smf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_start;

    modport source (output valid, output match_start, input ready);
    modport sink   (input valid, input match_start, output ready);
endinterface

>>> rtl/core/smf_cfg_regs.sv
module smf_cfg_regs
    import smf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output smf_cfg_t              cfg
);

    logic [APB_DATA_W-1:0] pattern_low_reg;
    logic [APB_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_len_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PATTERN_LOW:  pattern_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                REG_PATTERN_LEN:  pattern_len_reg  <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_PATTERN_LEN:  prdata = APB_DATA_W'(pattern_len_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.length  = pattern_len_reg;

endmodule

>>> rtl/core/smf_matcher.sv
module smf_matcher
    import smf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              starts_text,
    input  smf_cfg_t          cfg,
    output smf_result_t       result
);

    localparam int LEN_MAX    = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int HIST_DEPTH = (LEN_MAX > 1) ? LEN_MAX - 1 : 1;
    localparam int PIDX_W     = $clog2(REG_BYTES);

    logic [BYTE_W-1:0]  hist_reg  [HIST_DEPTH];
    logic [BYTE_W-1:0]  hist_next [HIST_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [BYTE_W-1:0]  pat [REG_BYTES];
    logic [BYTE_W-1:0]  win [LEN_MAX];
    logic [LEN_W-1:0]   act_len;
    logic [LEN_W-1:0]   len_m1;
    logic [COUNT_W-1:0] pos;

    always_comb
    begin
        for (int i = 0; i < REG_BYTES; i++)
        begin
            pat[i] = cfg.pattern[i*BYTE_W +: BYTE_W];
        end
    end

    // window: incoming byte first, then history, cleared at start of text
    always_comb
    begin
        win[0] = text_byte;
        for (int d = 1; d < LEN_MAX; d++)
        begin
            win[d] = starts_text ? '0 : hist_reg[d-1];
        end
    end

    assign act_len = (cfg.length > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : cfg.length;
    assign len_m1  = act_len - LEN_W'(1);
    assign pos     = starts_text ? '0 : count_reg;

    always_comb
    begin
        logic [LEN_W-1:0] pidx;
        logic             hit;
        hit  = (act_len != '0) && (pos >= COUNT_W'(len_m1));
        pidx = '0;
        for (int d = 0; d < LEN_MAX; d++)
        begin
            if (LEN_W'(d) < act_len)
            begin
                pidx = len_m1 - LEN_W'(d);
                if (win[d] != pat[pidx[PIDX_W-1:0]])
                begin
                    hit = 1'b0;
                end
            end
        end
        result.hit   = hit;
        result.start = pos - COUNT_W'(len_m1);
    end

    always_comb
    begin
        hist_next[0] = text_byte;
        for (int i = 1; i < HIST_DEPTH; i++)
        begin
            hist_next[i] = starts_text ? '0 : hist_reg[i-1];
        end
        count_next = (pos == '1) ? pos : pos + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (step)
        begin
            hist_reg  <= hist_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/substring_match_finder.sv
// Substring match finder. Text bytes enter on in_item; after each byte the block compares
// the last pattern_length bytes of the current text against the pattern and, on a match,
// sends one item on out_item carrying the text position of the occurrence's first byte
// (overlapping occurrences all reported). starts_text marks the first byte of a new text
// and restarts the position count at zero; positions saturate at 2^32-1. Throughput is
// one byte per cycle while out_item does not stall, set by the parallel window compare
// between the input register and the result register; a result item is registered when
// its byte leaves the input register. Program the pattern (APB, 64-bit data, registers at
// byte offsets 0x0, 0x8, 0x10) only while no bytes are in flight.
module substring_match_finder
    import smf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    smf_in_if.sink                in_item,
    smf_out_if.source             out_item
);

    smf_cfg_t           cfg;
    smf_result_t        result;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_start_reg;
    logic               advance;

    assign pready = 1'b1;

    smf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    smf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_matcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .starts_text (in_start_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // item moves from input register to result register when the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_item.ready)
        begin
            in_valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            in_byte_reg  <= in_item.text_byte;
            in_start_reg <= in_item.starts_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.hit;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_start_reg <= result.start;
        end
    end

    assign out_item.valid       = out_valid_reg;
    assign out_item.match_start = out_start_reg;

`ifndef ASSERT_OFF
    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered item lost while stalled");

    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without an item");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_item.ready |-> in_valid_reg && out_valid_reg && !out_item.ready)
        else $error("input stalled with room available");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import smf_pkg::*;

    localparam int ITEMS          = 1200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int GAP_MAX        = 13;

    class match_scoreboard;
        logic [63:0] pat_low;
        logic [63:0] pat_high;
        logic [4:0]  pat_len;
        logic [7:0]  history [0:14];
        logic [31:0] seen;
        logic [31:0] expected_starts [$];
        int          failures;
        int          checked;

        function new();
            failures = 0;
            checked  = 0;
            clear_text();
            pat_low  = '0;
            pat_high = '0;
            pat_len  = 5'd1;
        endfunction

        function void clear_text();
            for (int i = 0; i < 15; i++)
                history[i] = 8'h00;
            seen = '0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_LOW:  pat_low  = value;
                REG_PATTERN_HIGH: pat_high = value;
                REG_PATTERN_LEN:  pat_len  = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_at(int i);
            if (i < 8)
                return pat_low[8*i +: 8];
            return pat_high[8*(i-8) +: 8];
        endfunction

        function void note_byte(logic [7:0] b, logic st);
            int          len;
            logic [32:0] pos;
            bit          hit;
            if (st)
                clear_text();
            pos = {1'b0, seen};
            len = (pat_len > 5'd16) ? 16 : int'(pat_len);
            hit = (len != 0) && (pos + 33'd1 >= 33'(len));
            if (hit && pattern_at(len - 1) != b)
                hit = 0;
            for (int d = 1; hit && d < len; d++)
                if (history[d-1] != pattern_at(len - 1 - d))
                    hit = 0;
            if (hit)
                expected_starts = {expected_starts, 32'(pos + 33'd1 - 33'(len))};
            for (int d = 14; d > 0; d--)
                history[d] = history[d-1];
            history[0] = b;
            if (seen != 32'hFFFF_FFFF)
                seen++;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            failures++;
        endtask

        task check_start(logic [31:0] got);
            logic [31:0] want;
            if (expected_starts.size() == 0)
            begin
                report($sformatf("match_start %0d with no match pending", got));
                return;
            end
            want = expected_starts.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("match_start %0d, expected %0d", got, want));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    smf_in_if  in_if();
    smf_out_if out_if();

    substring_match_finder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_item  (in_if),
        .out_item (out_if)
    );

    match_scoreboard sb;
    int              in_gap_max;
    int              out_stall_max;
    int              bytes_sent;
    int              texts;
    int              settings;
    int              quiet;
    logic [7:0]      pat [0:15];
    int              plen;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.text_byte = '0;
        in_if.starts_text = 1'b0;
        out_if.ready = 1'b0;
        in_gap_max = 0;
        out_stall_max = 0;
        sb = new();
    end

    always #5 clk = ~clk;

    // result sink with random back-pressure
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!(out_if.valid && out_if.ready));
        end
    end

    always @(posedge clk)
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_start(out_if.match_start);

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check(reg_idx_t idx, logic [63:0] want);
        logic [63:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            sb.report($sformatf("register %s reads %h, expected %h", idx.name(), got, want));
    endtask

    task automatic load_pattern();
        logic [63:0] low_word;
        logic [63:0] high_word;
        for (int i = 0; i < 8; i++)
        begin
            low_word[8*i +: 8]  = pat[i];
            high_word[8*i +: 8] = pat[i+8];
        end
        apb_write(REG_PATTERN_LOW, low_word);
        apb_write(REG_PATTERN_HIGH, high_word);
        apb_write(REG_PATTERN_LEN, 64'(plen));
        apb_check(REG_PATTERN_LOW, low_word);
        apb_check(REG_PATTERN_HIGH, high_word);
        apb_check(REG_PATTERN_LEN, 64'(plen));
        settings++;
    endtask

    task automatic send_byte(logic [7:0] b, logic st);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.text_byte <= b;
        in_if.starts_text <= st;
        do @(posedge clk); while (!in_if.ready);
        sb.note_byte(b, st);
        bytes_sent++;
        if (st)
            texts++;
    endtask

    // hold the text until every pending match has come out and the pipe is empty
    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (sb.expected_starts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_occurrence(bit broken);
        logic [7:0] b;
        int         flip_at;
        flip_at = broken ? $urandom_range(0, plen - 1) : -1;
        for (int i = 0; i < plen; i++)
        begin
            b = pat[i];
            if (i == flip_at)
                b ^= 8'(1 << $urandom_range(0, 7));
            send_byte(b, ($urandom_range(0, 99) < 2) ? 1'b1 : 1'b0);
        end
    endtask

    task automatic run_phase(int phase);
        logic [7:0] alphabet [0:2];
        bit         full_range;
        int         n_items;
        int         start_count;
        int         r;
        for (int i = 0; i < 3; i++)
            alphabet[i] = 8'($urandom);
        full_range = ($urandom_range(0, 4) == 0);
        plen = (phase == 0) ? 1 : (phase == 1) ? 16 : $urandom_range(1, 16);
        for (int i = 0; i < 16; i++)
            pat[i] = (full_range || i >= plen) ? 8'($urandom)
                                               : alphabet[$urandom_range(0, 1)];
        load_pattern();
        in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        n_items = $urandom_range(100, 200);
        start_count = bytes_sent;
        send_byte(alphabet[0], 1'b1);
        while (bytes_sent - start_count < n_items)
        begin
            if (phase == 2 && bytes_sent - start_count > n_items / 2 &&
                bytes_sent - start_count <= n_items / 2 + plen)
                drain();
            r = $urandom_range(0, 99);
            if (r < 50)
                send_occurrence($urandom_range(0, 4) == 0);
            else if (r < 90)
                send_byte(alphabet[$urandom_range(0, 2)], ($urandom_range(0, 99) < 3));
            else
                send_byte(8'($urandom), ($urandom_range(0, 99) < 3));
        end
        drain();
    endtask

    initial
    begin
        int phase;
        bytes_sent = 0;
        texts = 0;
        settings = 0;
        quiet = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: single zero byte pattern
        apb_check(REG_PATTERN_LEN, 64'd1);
        apb_check(REG_PATTERN_LOW, 64'd0);
        send_byte(8'h00, 1'b1);
        drain();

        // overlapping occurrences, then a restart in the middle of one
        for (int i = 0; i < 16; i++)
            pat[i] = 8'h00;
        pat[0] = 8'hFF;
        pat[2] = 8'hFF;
        plen = 3;
        load_pattern();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // full length pattern at the very start of a text
        for (int i = 0; i < 16; i++)
            pat[i] = 8'($urandom);
        pat[3] = 8'hFF;
        pat[9] = 8'h00;
        plen = 16;
        load_pattern();
        for (int i = 0; i < 16; i++)
            send_byte(pat[i], (i == 0));
        drain();

        phase = 0;
        while (bytes_sent < ITEMS + 27)
        begin
            run_phase(phase);
            phase++;
        end

        repeat (10) @(posedge clk);
        while (sb.expected_starts.size() != 0)
            sb.report($sformatf("match_start %0d never came",
                                sb.expected_starts.pop_front()));
        $display("ran %0d text bytes over %0d texts with %0d pattern settings",
                 bytes_sent, texts, settings);
        $display("%0d match positions checked, %0d mismatches", sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/core/smf_pkg.sv
rtl/core/smf_in_if.sv
rtl/core/smf_out_if.sv
rtl/core/smf_cfg_regs.sv
rtl/core/smf_matcher.sv
rtl/core/substring_match_finder.sv
test/testbench.sv
